// File: src/skt_pkg.sv
package skt_pkg;

  // Command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_REWIND = 3'd4;
  localparam logic [2:0] CMD_NEXT   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_PAST_END  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic [63:0]        name_tag;
    logic [9:0]         grade;
  } skt_cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] out_key;
    logic [63:0]        out_name_tag;
    logic [9:0]         out_grade;
    logic [6:0]         count;
    logic               full_res;
  } skt_res_t;

  // One stored record
  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_tag;
    logic [9:0]         grade;
  } skt_rec_t;

  // Key compare flags: a < b, a == b, a > b
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } skt_cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_CHK,
    S_LK_RD,
    S_LK_CHK,
    S_NX_CHK
  } skt_state_e;

endpackage

// File: src/skt_mem.sv
module skt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  skt_pkg::skt_rec_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output skt_pkg::skt_rec_t rdata_o
);

  skt_pkg::skt_rec_t mem_q [DEPTH];
  skt_pkg::skt_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/skt_cmp.sv
module skt_cmp (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output skt_pkg::skt_cmp_t  cmp_o
);

  // Signed key compare shared by insert, delete and lookup
  always_comb begin
    cmp_o.lt = (a_i < b_i);
    cmp_o.eq = (a_i == b_i);
    cmp_o.gt = (a_i > b_i);
  end

endmodule

// File: src/skt_ctrl.sv
module skt_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  skt_pkg::skt_cmd_t cmd_i,
  output logic              busy_o,
  output logic              res_vld_o,
  output skt_pkg::skt_res_t res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output skt_pkg::skt_rec_t mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  skt_pkg::skt_rec_t mem_rdata_i
);

  localparam int SW = CW + 2;

  skt_pkg::skt_state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       iter_q, iter_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic signed [SW-1:0] lo_q, lo_d;
  logic signed [SW-1:0] hi_q, hi_d;
  logic [AW-1:0]       mid_q, mid_d;
  logic                found_q, found_d;
  skt_pkg::skt_cmd_t   op_q, op_d;

  logic [CW-1:0]        idx_m1;
  logic [CW-1:0]        idx_p1;
  logic signed [SW-1:0] mid_s;
  logic [31:0]          cnt_ext;
  skt_pkg::skt_rec_t    new_rec;
  skt_pkg::skt_cmp_t    cmp;
  logic                 emit;
  logic                 hit;
  logic [2:0]           st;

  function automatic logic [AW-1:0] mid_of(logic signed [SW-1:0] lo,
                                           logic signed [SW-1:0] hi);
    logic signed [SW-1:0] s;
    s = lo + hi;
    if (s < 0) begin
      return '0;
    end
    return s[AW:1];
  endfunction

  skt_cmp u_cmp (
    .a_i   (mem_rdata_i.key),
    .b_i   (op_q.key),
    .cmp_o (cmp)
  );

  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign mid_s  = $signed(SW'(mid_q));
  assign new_rec.key      = op_q.key;
  assign new_rec.name_tag = op_q.name_tag;
  assign new_rec.grade    = op_q.grade;
  assign busy_o = (state_q != skt_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
      cnt_q   <= '0;
      iter_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iter_q  <= iter_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    op_q  <= op_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    op_d        = op_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = new_rec;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    emit        = 1'b0;
    hit         = 1'b0;
    st          = skt_pkg::ST_OK;

    case (state_q)
      skt_pkg::S_IDLE: begin
        if (start_i) begin
          op_d = cmd_i;
          case (cmd_i.cmd)
            skt_pkg::CMD_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                emit = 1'b1;
                st   = skt_pkg::ST_FULL;
              end else begin
                idx_d   = cnt_q;
                state_d = skt_pkg::S_INS_RD;
              end
            end
            skt_pkg::CMD_DELETE: begin
              if (cnt_q == '0) begin
                emit = 1'b1;
                st   = skt_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = skt_pkg::S_DEL_RD;
              end
            end
            skt_pkg::CMD_LOOKUP: begin
              if (cnt_q == '0) begin
                emit = 1'b1;
                st   = skt_pkg::ST_EMPTY;
              end else begin
                lo_d    = '0;
                hi_d    = $signed({2'b00, cnt_q}) - SW'(1);
                mid_d   = mid_of(lo_d, hi_d);
                state_d = skt_pkg::S_LK_RD;
              end
            end
            skt_pkg::CMD_CLEAR: begin
              cnt_d  = '0;
              iter_d = '0;
              emit   = 1'b1;
            end
            skt_pkg::CMD_REWIND: begin
              iter_d = '0;
              emit   = 1'b1;
            end
            skt_pkg::CMD_NEXT: begin
              if (iter_q >= cnt_q) begin
                emit = 1'b1;
                st   = skt_pkg::ST_PAST_END;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = iter_q[AW-1:0];
                state_d     = skt_pkg::S_NX_CHK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      skt_pkg::S_INS_RD: begin
        if (idx_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          mem_wdata_o = new_rec;
          cnt_d       = cnt_q + CW'(1);
          emit        = 1'b1;
          state_d     = skt_pkg::S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_m1[AW-1:0];
          state_d     = skt_pkg::S_INS_WR;
        end
      end

      skt_pkg::S_INS_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        if (cmp.lt) begin
          mem_wdata_o = new_rec;
          cnt_d       = cnt_q + CW'(1);
          emit        = 1'b1;
          state_d     = skt_pkg::S_IDLE;
        end else begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_m1;
          state_d     = skt_pkg::S_INS_RD;
        end
      end

      skt_pkg::S_DEL_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q[AW-1:0];
        state_d     = skt_pkg::S_DEL_CHK;
      end

      skt_pkg::S_DEL_CHK: begin
        if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_m1[AW-1:0];
          mem_wdata_o = mem_rdata_i;
        end else if (cmp.eq) begin
          found_d = 1'b1;
        end
        if (idx_p1 == cnt_q) begin
          emit    = 1'b1;
          state_d = skt_pkg::S_IDLE;
          if (found_d) begin
            cnt_d = cnt_q - CW'(1);
          end else begin
            st = skt_pkg::ST_NOT_FOUND;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = skt_pkg::S_DEL_RD;
        end
      end

      skt_pkg::S_LK_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = mid_q;
        state_d     = skt_pkg::S_LK_CHK;
      end

      skt_pkg::S_LK_CHK: begin
        if ((lo_q <= hi_q) && !cmp.eq) begin
          if (cmp.gt) begin
            hi_d = mid_s - SW'(1);
          end else begin
            lo_d = mid_s + SW'(1);
          end
          mid_d   = mid_of(lo_d, hi_d);
          state_d = skt_pkg::S_LK_RD;
        end else begin
          emit    = 1'b1;
          state_d = skt_pkg::S_IDLE;
          if (cmp.eq) begin
            hit = 1'b1;
          end else begin
            st = skt_pkg::ST_NOT_FOUND;
          end
        end
      end

      skt_pkg::S_NX_CHK: begin
        hit     = 1'b1;
        iter_d  = iter_q + CW'(1);
        emit    = 1'b1;
        state_d = skt_pkg::S_IDLE;
      end

      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  assign cnt_ext = 32'(cnt_d);

  always_comb begin
    res_vld_o           = emit;
    res_o.status        = st;
    res_o.found         = hit;
    res_o.out_key       = hit ? mem_rdata_i.key : '0;
    res_o.out_name_tag  = hit ? mem_rdata_i.name_tag : '0;
    res_o.out_grade     = hit ? mem_rdata_i.grade : '0;
    res_o.count         = cnt_ext[6:0];
    res_o.full_res      = (cnt_d == CW'(DEPTH));
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + 1 || cnt_q + 1 == $past(cnt_q) || cnt_q == '0))
    else $error("entry count moved by more than one");

  a_iter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iter_q != $past(iter_q)) |-> (iter_q == '0 || iter_q == $past(iter_q) + 1))
    else $error("iterator jumped");

  a_mid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::S_LK_RD) |-> (CW'(mid_q) < cnt_q))
    else $error("search probe outside the filled entries");

endmodule

// File: src/sorted_key_table.sv
// Sorted key table: up to DEPTH records (signed key, 64-bit name tag, grade)
// held in ascending key order in a single-port-write, single-port-read RAM.
// A command transfers when start is high and busy is low; exactly one result
// follows on res_o, with res_valid_o high for a single cycle, in the cycle
// after the command finishes. The receiver cannot stall, so capture it then.
// Clear, rewind, unknown codes, insert into a full table, delete or lookup on
// an empty table and next past the end finish in the transfer cycle; next
// with an entry issues its read on transfer and finishes in S_NX_CHK. Insert
// walks down from the top, moving one record up per read in S_INS_RD and
// write in S_INS_WR until the slot is found. Delete scans and compacts the
// whole table. Lookup is a midpoint binary search, each probe a read in
// S_LK_RD and a compare in S_LK_CHK. The worst case, a delete on a full
// table, is set by the one read and one write per cycle of the record RAM
// and its registered read. busy is high while a command is in progress; the
// next command may be given in the cycle the previous result is on the ports.
module sorted_key_table #(
  parameter int DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  skt_pkg::skt_cmd_t cmd_i,
  output logic              busy,
  output logic              res_valid_o,
  output skt_pkg::skt_res_t res_o
);

  // Address width for the RAM, count width that can hold DEPTH itself
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  skt_pkg::skt_rec_t mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  skt_pkg::skt_rec_t mem_rdata;

  logic              res_vld;
  skt_pkg::skt_res_t res;

  logic              res_valid_q;
  skt_pkg::skt_res_t res_q;

  // Record storage
  skt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Command sequencer with the shared key comparator
  skt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .busy_o      (busy),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Register the result: the strobe lasts exactly one cycle per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_vld;
    end
  end

  // Hold payload only when a new result lands
  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      res_q <= res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: bench/sorted_key_table_test.sv
`timescale 1ns / 1ps

module sorted_key_table_test;
  import skt_pkg::*;

  localparam int DEPTH = 64;
  // The package names only the six real commands; the two spare codes
  // must do nothing but report the count.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  // Slowest command: a delete that scans a full table.
  localparam int CMD_CYCLES = 2 * DEPTH + 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STEADY_TAIL = 150;

  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_WALK,
    MOOD_MIX
  } mood_e;

  typedef struct {
    skt_cmd_t c;
    bit       typed;
    skt_res_t want;
  } plan_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  skt_cmd_t cmd_i = '0;
  logic     busy;
  logic     res_valid_o;
  skt_res_t res_o;

  // Shadow copy of the table; entries at or above shadow_count are never read.
  logic signed [31:0] shadow_key [DEPTH];
  logic [63:0]        shadow_tag [DEPTH];
  logic [9:0]         shadow_grade [DEPTH];
  int                 shadow_count = 0;
  int                 walk_pos = 0;

  skt_res_t owed_replies [$];
  skt_res_t head;
  int       miss_count = 0;
  int       quiet_cycles = 0;

  sorted_key_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply one command to the shadow table and return the reply it owes.
  function automatic skt_res_t apply_to_shadow(input skt_cmd_t c);
    skt_res_t r;
    int       slot;
    int       i;
    int       lo;
    int       hi;
    int       mid;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // New key lands ahead of any equal keys.
          slot = 0;
          while (slot < shadow_count && shadow_key[slot] < c.key) slot++;
          for (i = shadow_count; i > slot; i--) begin
            shadow_key[i] = shadow_key[i - 1];
            shadow_tag[i] = shadow_tag[i - 1];
            shadow_grade[i] = shadow_grade[i - 1];
          end
          shadow_key[slot] = c.key;
          shadow_tag[slot] = c.name_tag;
          shadow_grade[slot] = c.grade;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = shadow_count;
          for (i = 0; i < shadow_count && slot == shadow_count; i++) begin
            if (shadow_key[i] == c.key) slot = i;
          end
          if (slot == shadow_count) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (i = slot; i + 1 < shadow_count; i++) begin
              shadow_key[i] = shadow_key[i + 1];
              shadow_tag[i] = shadow_tag[i + 1];
              shadow_grade[i] = shadow_grade[i + 1];
            end
            shadow_count--;
          end
        end
      end
      CMD_LOOKUP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Plain midpoint search; with duplicates the first probe to hit wins.
          lo = 0;
          hi = shadow_count - 1;
          mid = (lo + hi) / 2;
          while (lo <= hi && shadow_key[mid] != c.key) begin
            if (c.key < shadow_key[mid]) hi = mid - 1;
            else lo = mid + 1;
            mid = (lo + hi) / 2;
          end
          if (mid >= 0 && mid < shadow_count && shadow_key[mid] == c.key) begin
            r.found = 1'b1;
            r.out_key = shadow_key[mid];
            r.out_name_tag = shadow_tag[mid];
            r.out_grade = shadow_grade[mid];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        walk_pos = 0;
      end
      CMD_REWIND: walk_pos = 0;
      CMD_NEXT: begin
        // Past the end the iterator holds where it is.
        if (walk_pos >= shadow_count) begin
          r.status = ST_PAST_END;
        end else begin
          r.found = 1'b1;
          r.out_key = shadow_key[walk_pos];
          r.out_name_tag = shadow_tag[walk_pos];
          r.out_grade = shadow_grade[walk_pos];
          walk_pos++;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[6:0];
    r.full_res = (shadow_count == DEPTH);
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] op, input logic signed [31:0] k,
                                         input logic [63:0] tag, input logic [9:0] g,
                                         input bit typed, input logic [2:0] st,
                                         input int cnt);
    plan_row_t row;
    row.c.cmd = op;
    row.c.key = k;
    row.c.name_tag = tag;
    row.c.grade = g;
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.count = cnt[6:0];
    row.want.full_res = (cnt == DEPTH);
    return row;
  endfunction

  // Draw a key: often one already held, so deletes and lookups hit and
  // inserts pile up duplicates; otherwise a corner value, a narrow band, or
  // anything at all.
  function automatic logic signed [31:0] pick_key(input int hit_pct);
    if (shadow_count > 0 && $urandom_range(99) < hit_pct)
      return shadow_key[$urandom_range(shadow_count - 1)];
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(5))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return -32'sd1;
          3: return 32'sd0;
          4: return 32'sh7FFF_FFFE;
          default: return 32'sh7FFF_FFFF;
        endcase
      end
      1: return $signed($urandom_range(40)) - 32'sd20;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input mood_e mood);
    int roll;
    roll = $urandom_range(99);
    case (mood)
      MOOD_FILL:
        return roll < 88 ? CMD_INSERT : roll < 94 ? CMD_LOOKUP : CMD_NEXT;
      MOOD_DRAIN:
        return roll < 60 ? CMD_DELETE : roll < 85 ? CMD_LOOKUP :
               roll < 95 ? CMD_INSERT : CMD_NEXT;
      MOOD_WALK:
        return roll < 15 ? CMD_REWIND : roll < 80 ? CMD_NEXT :
               roll < 90 ? CMD_INSERT : CMD_DELETE;
      default:
        return roll < 32 ? CMD_INSERT : roll < 52 ? CMD_DELETE :
               roll < 76 ? CMD_LOOKUP : roll < 86 ? CMD_NEXT :
               roll < 91 ? CMD_REWIND : roll < 93 ? CMD_CLEAR :
               roll < 96 ? CMD_SPARE_A : CMD_SPARE_B;
    endcase
  endfunction

  // Present one command and hold it until the transfer; then book the reply,
  // either the one typed into the plan or the shadow table's own.
  task automatic issue(input skt_cmd_t c, input bit typed, input skt_res_t given);
    skt_res_t owed;
    cmd_i <= c;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    owed = apply_to_shadow(c);
    owed_replies.push_back(typed ? given : owed);
  endtask

  // Drop start for an idle burst.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(posedge clk_i);
  endtask

  // Hold off until every booked reply has come back.
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk_i);
    while (owed_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      miss_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Check each reply against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (owed_replies.size() == 0) begin
        miss_count++;
        $display("%0t: reply expected none got %p", $time, res_o);
      end else begin
        head = owed_replies.pop_front();
        note_field("status", head.status, res_o.status);
        note_field("found", head.found, res_o.found);
        note_field("out_key", head.out_key, res_o.out_key);
        note_field("out_name_tag", head.out_name_tag, res_o.out_name_tag);
        note_field("out_grade", head.out_grade, res_o.out_grade);
        note_field("count", head.count, res_o.count);
        note_field("full_res", head.full_res, res_o.full_res);
      end
    end
  end

  // Give up once nothing has transferred in either direction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t opening [$];
    skt_cmd_t  c;
    mood_e     mood;
    int        mood_left;
    bit        gappy;
    int        gap_left;
    int        n;

    // Walk the corners: empty table, key and field extremes, duplicates,
    // misses, the iterator running off the end, spare codes and clear.
    opening.push_back(plan_row(CMD_LOOKUP, 32'sd0, '0, '0, 1, ST_EMPTY, 0));
    opening.push_back(plan_row(CMD_DELETE, 32'sd0, '0, '0, 1, ST_EMPTY, 0));
    opening.push_back(plan_row(CMD_NEXT, 32'sd0, '0, '0, 1, ST_PAST_END, 0));
    opening.push_back(plan_row(CMD_INSERT, 32'sh7FFF_FFFF, '1, 10'd1023, 1, ST_OK, 1));
    opening.push_back(plan_row(CMD_INSERT, 32'sh8000_0000, '0, 10'd0, 1, ST_OK, 2));
    opening.push_back(plan_row(CMD_INSERT, 32'sd0, 64'h0123_4567_89AB_CDEF, 10'd512, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_INSERT, 32'sd0, 64'hFEDC_BA98_7654_3210, 10'd1, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_INSERT, -32'sd1, 64'h5555_AAAA_5555_AAAA, 10'd341, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_LOOKUP, 32'sh7FFF_FFFF, '0, '0, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_LOOKUP, 32'sh8000_0000, '0, '0, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_LOOKUP, 32'sd0, '0, '0, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_LOOKUP, 32'sd5, '0, '0, 1, ST_NOT_FOUND, 5));
    opening.push_back(plan_row(CMD_DELETE, 32'sd5, '0, '0, 1, ST_NOT_FOUND, 5));
    opening.push_back(plan_row(CMD_REWIND, 32'sd0, '0, '0, 1, ST_OK, 5));
    repeat (5) opening.push_back(plan_row(CMD_NEXT, 32'sd0, '0, '0, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_NEXT, 32'sd0, '0, '0, 1, ST_PAST_END, 5));
    opening.push_back(plan_row(CMD_DELETE, 32'sd0, '0, '0, 0, ST_OK, 0));
    opening.push_back(plan_row(CMD_SPARE_A, 32'sd0, '0, '0, 1, ST_OK, 4));
    opening.push_back(plan_row(CMD_SPARE_B, 32'sd0, '0, '0, 1, ST_OK, 4));
    opening.push_back(plan_row(CMD_NEXT, 32'sd0, '0, '0, 1, ST_PAST_END, 4));
    opening.push_back(plan_row(CMD_CLEAR, 32'sd0, '0, '0, 1, ST_OK, 0));
    opening.push_back(plan_row(CMD_NEXT, 32'sd0, '0, '0, 1, ST_PAST_END, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) begin
      issue(opening[i].c, opening[i].typed, opening[i].want);
      if ($urandom_range(3) == 0) idle_burst();
    end
    drain_replies();

    // Random traffic in moods: fill runs push the table to full and past it,
    // drain runs empty it, walk runs exercise the iterator, mixed runs do all.
    mood = MOOD_FILL;
    mood_left = $urandom_range(70, 110);
    gappy = 1'b1;
    gap_left = $urandom_range(50, 150);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (mood_left == 0) begin
        mood = mood_e'($urandom_range(3));
        mood_left = $urandom_range(40, 120);
      end
      mood_left--;
      if (gap_left == 0) begin
        gappy = !gappy;
        gap_left = $urandom_range(50, 150);
      end
      gap_left--;

      c.cmd = pick_op(mood);
      c.key = pick_key(c.cmd == CMD_INSERT ? 30 : 80);
      c.name_tag = {$urandom, $urandom};
      c.grade = $urandom_range(1023);
      issue(c, 1'b0, '0);

      // Run the tail at full rate.
      if (n < RANDOM_ITEMS - STEADY_TAIL) begin
        if ($urandom_range(99) == 0) drain_replies();
        else if (gappy && $urandom_range(3) == 0) idle_burst();
      end
    end
    start <= 1'b0;

    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (CMD_CYCLES) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
